@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ODS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ODS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ods_pkg.sv @@
package ods_pkg;

    localparam int TargetW  = 31;
    localparam int XtalW    = 48;
    localparam int DcoW     = 33;
    localparam int RatioW   = 38;
    localparam int N1W      = 8;
    localparam int HsW      = 4;
    localparam int FhW      = TargetW + HsW;
    localparam int FdcoW    = 43;
    localparam int HsCount  = 6;
    localparam int HsIdxW   = 3;
    localparam int FracSh   = 44;
    localparam int DivNumW  = 86;
    localparam int DivDenW  = 48;
    localparam int DivCntW  = 7;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 48;

    localparam logic [N1W-1:0] N1Limit = 8'd128;

    localparam logic [CfgIdxW-1:0] CFG_XTAL    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_DCO_MIN = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DCO_MAX = 2'd2;

    localparam logic [XtalW-1:0] XtalReset   = 48'd7489781760000;
    localparam logic [DcoW-1:0]  DcoMinReset = 33'd4850000000;
    localparam logic [DcoW-1:0]  DcoMaxReset = 33'd5670000000;

    // High-speed divider search order
    function automatic logic [HsW-1:0] hs_of(input logic [HsIdxW-1:0] idx);
        logic [HsW-1:0] hs;
        unique case (idx)
            3'd0:    hs = 4'd11;
            3'd1:    hs = 4'd9;
            3'd2:    hs = 4'd7;
            3'd3:    hs = 4'd6;
            3'd4:    hs = 4'd5;
            default: hs = 4'd4;
        endcase
        return hs;
    endfunction

    typedef struct packed {
        logic load;
        logic div_min;
        logic div_f;
        logic div_ratio;
        logic seed;
        logic mult;
        logic step;
        logic take;
        logic next_hs;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic zero_f;
        logic div_busy;
        logic seed_skip;
        logic scan_over;
        logic scan_hit;
        logic last_hs;
        logic found;
    } sts_t;

endpackage

@@ rtl/oscillator_divider_search.sv @@
// Each word tries the six high-speed dividers in turn, each scanning up to 65 N1 steps
// (usually 1 to 4); a zero target skips the search and reports status high.
// Throughput: one word at a time; all divisions share the one-bit-per-cycle divider.
// Reset: rst_n, asynchronous active low, clears control and loads register defaults.
module oscillator_divider_search (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [ods_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ods_pkg::CfgDataW-1:0]  cfg_data,
    // input word
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ods_pkg::TargetW-1:0]   target_hz,
    // result word
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ods_pkg::RatioW-1:0]    ratio_word,
    output logic [ods_pkg::N1W-1:0]       out_divider,
    output logic [ods_pkg::HsW-1:0]       speed_divider,
    output logic                          status
);
    import ods_pkg::*;

    // Per divider HS: dco_min/HS then /target on the shared divider, seed N1, one
    // multiply for fdco, then step N1 by two adding 2*f*HS (by one from N1 = 1, adding f*HS).
    // The ratio is a final 86-bit by 48-bit division.
    // The result register frees the controller as soon as the word is loaded.

    cmd_t cmd;
    sts_t sts;

    ods_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ods_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .target_hz     (target_hz),
        .cmd           (cmd),
        .sts           (sts),
        .ratio_word    (ratio_word),
        .out_divider   (out_divider),
        .speed_divider (speed_divider),
        .status        (status)
    );

endmodule

@@ rtl/ods_div.sv @@
`include "assert_macros.svh"

module ods_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ods_pkg::DivNumW-1:0]  num_in,
    input  logic [ods_pkg::DivDenW-1:0]  den_in,
    input  logic [ods_pkg::DivCntW-1:0]  cnt_in,
    output logic                         busy,
    output logic [ods_pkg::DivNumW-1:0]  quot
);
    import ods_pkg::*;

    // restoring divider, one quotient bit per cycle; quotient shifts into num
    logic [DivNumW-1:0] num_reg;
    logic [DivDenW-1:0] den_reg;
    logic [DivDenW-1:0] rem_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic               busy_reg;
    logic [DivDenW:0]   sh;
    logic [DivDenW:0]   diff;
    logic               ge;

    assign sh   = {rem_reg, num_reg[DivNumW-1]};
    assign ge   = sh >= {1'b0, den_reg};
    assign diff = sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= cnt_in;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DivCntW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num_in;
            den_reg <= den_in;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DivNumW-2:0], ge};
            rem_reg <= ge ? diff[DivDenW-1:0] : sh[DivDenW-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

    `ODS_ASSERT_NXT(a_div_runs, busy_reg && !start && cnt_reg != DivCntW'(1), busy_reg,
        "divider stopped early")

endmodule

@@ rtl/ods_datapath.sv @@
`include "assert_macros.svh"

module ods_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ods_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ods_pkg::CfgDataW-1:0]  cfg_data,
    input  logic [ods_pkg::TargetW-1:0]   target_hz,
    input  ods_pkg::cmd_t                 cmd,
    output ods_pkg::sts_t                 sts,
    output logic [ods_pkg::RatioW-1:0]    ratio_word,
    output logic [ods_pkg::N1W-1:0]       out_divider,
    output logic [ods_pkg::HsW-1:0]       speed_divider,
    output logic                          status
);
    import ods_pkg::*;

    logic [XtalW-1:0]   xtal_reg;
    logic [DcoW-1:0]    dmin_reg;
    logic [DcoW-1:0]    dmax_reg;
    logic [TargetW-1:0] f_reg;
    logic [HsIdxW-1:0]  hs_idx_reg;
    logic [FhW-1:0]     fh_reg;
    logic [N1W-1:0]     n1_reg;
    logic [FdcoW-1:0]   fdco_reg;
    logic               found_reg;
    logic [FdcoW-1:0]   best_fdco_reg;
    logic [N1W-1:0]     best_n1_reg;
    logic [HsW-1:0]     best_hs_reg;
    logic [RatioW-1:0]  ratio_reg;
    logic [N1W-1:0]     n1_out_reg;
    logic [HsW-1:0]     hs_out_reg;
    logic               status_reg;

    logic [HsW-1:0]     hs_cur;
    logic               div_start;
    logic [DivNumW-1:0] div_num;
    logic [DivDenW-1:0] div_den;
    logic [DivCntW-1:0] div_cnt;
    logic               div_busy;
    logic [DivNumW-1:0] div_quot;
    logic [DcoW-1:0]    q33;
    logic [N1W-1:0]     n1_seed;

    assign hs_cur    = hs_of(hs_idx_reg);
    assign div_start = cmd.div_min | cmd.div_f | cmd.div_ratio;
    assign q33       = div_quot[DcoW-1:0];

    always_comb
    begin
        priority if (cmd.div_ratio)
        begin
            div_num = {best_fdco_reg[DivNumW-FracSh-1:0], {FracSh{1'b0}}};
            div_den = xtal_reg;
            div_cnt = DivCntW'(DivNumW);
        end
        else if (cmd.div_f)
        begin
            div_num = {q33, {(DivNumW-DcoW){1'b0}}};
            div_den = {{(DivDenW-TargetW){1'b0}}, f_reg};
            div_cnt = DivCntW'(DcoW);
        end
        else
        begin
            div_num = {dmin_reg, {(DivNumW-DcoW){1'b0}}};
            div_den = {{(DivDenW-HsW){1'b0}}, hs_cur};
            div_cnt = DivCntW'(DcoW);
        end
    end

    ods_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_in (div_num),
        .den_in (div_den),
        .cnt_in (div_cnt),
        .busy   (div_busy),
        .quot   (div_quot)
    );

    // start of N1: zero or odd goes up by one
    assign n1_seed = (q33[N1W-1:0] == '0 || q33[0]) ? q33[N1W-1:0] + 1'b1 : q33[N1W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xtal_reg  <= XtalReset;
            dmin_reg  <= DcoMinReset;
            dmax_reg  <= DcoMaxReset;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_XTAL:    xtal_reg <= cfg_data;
                    CFG_DCO_MIN: dmin_reg <= cfg_data[DcoW-1:0];
                    CFG_DCO_MAX: dmax_reg <= cfg_data[DcoW-1:0];
                    default:     ;
                endcase
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            f_reg      <= target_hz;
            hs_idx_reg <= '0;
        end
        if (cmd.next_hs)
        begin
            hs_idx_reg <= hs_idx_reg + 1'b1;
        end
        if (cmd.div_min)
        begin
            fh_reg <= FhW'(f_reg) * FhW'(hs_cur);
        end
        if (cmd.seed)
        begin
            n1_reg <= n1_seed;
        end
        if (cmd.mult)
        begin
            fdco_reg <= FdcoW'(fh_reg) * FdcoW'(n1_reg);
        end
        if (cmd.step)
        begin
            if (n1_reg == N1W'(1))
            begin
                n1_reg   <= n1_reg + 1'b1;
                fdco_reg <= fdco_reg + FdcoW'(fh_reg);
            end
            else
            begin
                n1_reg   <= n1_reg + N1W'(2);
                fdco_reg <= fdco_reg + FdcoW'({fh_reg, 1'b0});
            end
        end
        // strictly lower wins, so the first match keeps a tie
        if (cmd.take && (!found_reg || fdco_reg < best_fdco_reg))
        begin
            best_fdco_reg <= fdco_reg;
            best_n1_reg   <= n1_reg;
            best_hs_reg   <= hs_cur;
        end
        if (cmd.out_load)
        begin
            if (found_reg)
            begin
                ratio_reg  <= div_quot[RatioW-1:0];
                n1_out_reg <= best_n1_reg;
                hs_out_reg <= best_hs_reg;
                status_reg <= 1'b0;
            end
            else
            begin
                ratio_reg  <= '0;
                n1_out_reg <= '0;
                hs_out_reg <= '0;
                status_reg <= 1'b1;
            end
        end
    end

    assign sts.zero_f    = (f_reg == '0);
    assign sts.div_busy  = div_busy;
    assign sts.seed_skip = (q33[DcoW-1:N1W] != '0) || (q33[N1W-1:0] > N1Limit);
    assign sts.scan_over = (n1_reg > N1Limit) || (fdco_reg > FdcoW'(dmax_reg));
    assign sts.scan_hit  = (fdco_reg >= FdcoW'(dmin_reg));
    assign sts.last_hs   = (hs_idx_reg == HsIdxW'(HsCount - 1));
    assign sts.found     = found_reg;

    assign ratio_word    = ratio_reg;
    assign out_divider   = n1_out_reg;
    assign speed_divider = hs_out_reg;
    assign status        = status_reg;

    `ODS_ASSERT_NXT(a_take_found, cmd.take, found_reg,
        "match taken but found flag not set")

endmodule

@@ rtl/ods_ctrl.sv @@
`include "assert_macros.svh"

module ods_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  ods_pkg::sts_t  sts,
    output ods_pkg::cmd_t  cmd
);
    import ods_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE       = 12'b0000_0000_0001,
        ST_START      = 12'b0000_0000_0010,
        ST_DIVA_GO    = 12'b0000_0000_0100,
        ST_DIVA_WAIT  = 12'b0000_0000_1000,
        ST_DIVB_GO    = 12'b0000_0001_0000,
        ST_DIVB_WAIT  = 12'b0000_0010_0000,
        ST_SEED       = 12'b0000_0100_0000,
        ST_MULT       = 12'b0000_1000_0000,
        ST_SCAN       = 12'b0001_0000_0000,
        ST_NEXT       = 12'b0010_0000_0000,
        ST_RATIO_WAIT = 12'b0100_0000_0000,
        ST_DONE       = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = sts.zero_f ? ST_DONE : ST_DIVA_GO;
            end
            ST_DIVA_GO:
            begin
                cmd.div_min = 1'b1;
                state_next  = ST_DIVA_WAIT;
            end
            ST_DIVA_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_DIVB_GO;
                end
            end
            ST_DIVB_GO:
            begin
                cmd.div_f  = 1'b1;
                state_next = ST_DIVB_WAIT;
            end
            ST_DIVB_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                cmd.seed   = 1'b1;
                state_next = sts.seed_skip ? ST_NEXT : ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // the first in-window value is the lowest for this divider
                priority if (sts.scan_over)
                begin
                    state_next = ST_NEXT;
                end
                else if (sts.scan_hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_NEXT;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_NEXT:
            begin
                if (!sts.last_hs)
                begin
                    cmd.next_hs = 1'b1;
                    state_next  = ST_DIVA_GO;
                end
                else if (sts.found)
                begin
                    cmd.div_ratio = 1'b1;
                    state_next    = ST_RATIO_WAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RATIO_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `ODS_ASSERT_NXT(a_load_valid, cmd.out_load, out_valid_reg && state_reg == ST_IDLE,
        "result load did not raise valid")
    `ODS_ASSERT_IMP(a_scan_div_idle, state_reg == ST_SCAN || state_reg == ST_DONE,
        !sts.div_busy, "divider busy outside a wait state")

endmodule
